/* rtl/mtes_pkg.sv */
// ----------------------------------------------------------------------------
// mtes_pkg
// Types, constants and byte tables shared by the SMF track serializer.
// ----------------------------------------------------------------------------
package mtes_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] event_time_ms;
        logic [23:0] message;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        last;
        logic [31:0] track_length;
    } t_out_item;

    // classified transaction handed from the front end to the byte engine
    typedef struct packed {
        logic [1:0]  action;
        logic [27:0] delta;
        logic [23:0] message;
        logic [1:0]  vlq_last;   // number of delta bytes minus one
        logic [1:0]  msg_len;    // number of message bytes
    } t_cmd;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_EVENT = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // ms*24/125: q = ms/125 via reciprocal 2^32 + RECIP_LO, shift 39
    localparam logic [26:0] RECIP_LO   = 27'd103079216;
    localparam logic [15:0] FRAC_MUL   = 16'd33555;    // ceil(2^22/125)
    localparam int          FRAC_SHIFT = 22;

    localparam logic [27:0] DELTA_MAX = 28'hFFF_FFFF;

    localparam logic [4:0] START_LAST  = 5'd28;
    localparam logic [4:0] TRACK_FIRST = 5'd22;
    localparam logic [4:0] END_LAST    = 5'd3;

    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_AT   = 4'hA;
    localparam logic [3:0] ST_CTRL      = 4'hB;
    localparam logic [3:0] ST_PROGRAM   = 4'hC;
    localparam logic [3:0] ST_CHAN_AT   = 4'hD;
    localparam logic [3:0] ST_PITCH     = 4'hE;

    localparam logic [7:0] META_PREFIX  = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_EOT     = 8'h2F;

    // file header, track header, delta 0 and the 120 BPM tempo event
    function automatic logic [7:0] start_byte(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h4D;
            5'd1:    b = 8'h54;
            5'd2:    b = 8'h68;
            5'd3:    b = 8'h64;
            5'd7:    b = 8'h06;
            5'd11:   b = 8'h01;
            5'd13:   b = 8'h60;
            5'd14:   b = 8'h4D;
            5'd15:   b = 8'h54;
            5'd16:   b = 8'h72;
            5'd17:   b = 8'h6B;
            5'd23:   b = META_PREFIX;
            5'd24:   b = META_TEMPO;
            5'd25:   b = 8'h03;
            5'd26:   b = 8'h07;
            5'd27:   b = 8'hA1;
            5'd28:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] end_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd1:    b = META_PREFIX;
            2'd2:    b = META_EOT;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/mtes_front.sv */
// ----------------------------------------------------------------------------
// mtes_front
// Accepts transactions, converts ms to ticks over three stages, forms the
// tick delta and classifies the message length before queueing.
// ----------------------------------------------------------------------------
module mtes_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mtes_pkg::t_in_item i_in_data,
    output logic              o_push,
    output mtes_pkg::t_cmd    o_cmd,
    input  logic              i_full
);
    import mtes_pkg::*;

    logic        adv;

    logic        r_v1;
    logic [1:0]  r_act1;
    logic [23:0] r_msg1;
    logic [31:0] r_ms1;
    logic [58:0] r_prod1;

    logic        r_v2;
    logic [1:0]  r_act2;
    logic [23:0] r_msg2;
    logic [25:0] r_q2;
    logic [6:0]  r_r2;

    logic        r_v3;
    logic [1:0]  r_act3;
    logic [23:0] r_msg3;
    logic [31:0] r_tick3;

    logic [31:0] r_prev_tick;

    logic [32:0] sum1;
    logic [25:0] q1;
    logic [31:0] rem1;
    logic [11:0] t24;
    logic [27:0] fprod;
    logic [4:0]  frac;
    logic [31:0] tick2;
    logic [31:0] diff;
    logic [27:0] delta;
    logic [1:0]  vlq_last;
    logic [1:0]  msg_len;

    assign adv        = !r_v3 || !i_full;
    assign o_in_stall = !adv;

    assign sum1  = {1'b0, r_ms1} + {6'b0, r_prod1[58:32]};
    assign q1    = sum1[32:7];
    assign rem1  = r_ms1 - 32'(32'(q1) * 32'd125);

    assign t24   = 12'(12'(r_r2) * 12'd24);
    assign fprod = 28'(t24) * 28'(FRAC_MUL);
    assign frac  = fprod[FRAC_SHIFT +: 5];
    assign tick2 = 32'(32'(r_q2) * 32'd24) + 32'(frac);

    always_comb begin
        diff = r_tick3 - r_prev_tick;
        if (r_act3 != ACT_EVENT || r_tick3 < r_prev_tick) begin
            delta = '0;
        end else if (diff > 32'(DELTA_MAX)) begin
            delta = DELTA_MAX;
        end else begin
            delta = diff[27:0];
        end
        priority if (delta[27:21] != '0) begin
            vlq_last = 2'd3;
        end else if (delta[20:14] != '0) begin
            vlq_last = 2'd2;
        end else if (delta[13:7] != '0) begin
            vlq_last = 2'd1;
        end else begin
            vlq_last = 2'd0;
        end
        msg_len = 2'd0;
        if (r_act3 == ACT_EVENT) begin
            unique case (r_msg3[7:4])
                ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH: msg_len = 2'd3;
                ST_PROGRAM, ST_CHAN_AT:                                msg_len = 2'd2;
                default:                                               msg_len = 2'd0;
            endcase
        end
    end

    assign o_push = r_v3 && !i_full &&
                    (r_act3 == ACT_START || r_act3 == ACT_EVENT || r_act3 == ACT_END);
    assign o_cmd  = '{action: r_act3, delta: delta, message: r_msg3,
                      vlq_last: vlq_last, msg_len: msg_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_prev_tick <= '0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3 && r_act3 == ACT_EVENT) begin
                r_prev_tick <= r_tick3;
            end else if (r_v3 && r_act3 == ACT_START) begin
                r_prev_tick <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_act1  <= i_in_data.action;
            r_msg1  <= i_in_data.message;
            r_ms1   <= i_in_data.event_time_ms;
            r_prod1 <= 59'(i_in_data.event_time_ms) * 59'(RECIP_LO);
            r_act2  <= r_act1;
            r_msg2  <= r_msg1;
            r_q2    <= q1;
            r_r2    <= rem1[6:0];
            r_act3  <= r_act2;
            r_msg3  <= r_msg2;
            r_tick3 <= tick2;
        end
    end

endmodule

/* rtl/mtes_fifo.sv */
// ----------------------------------------------------------------------------
// mtes_fifo
// Small register queue between the front end and the byte engine.
// ----------------------------------------------------------------------------
module mtes_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtes_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output mtes_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import mtes_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/mtes_back.sv */
// ----------------------------------------------------------------------------
// mtes_back
// Byte engine: walks the head transaction one byte a cycle into the output
// register, unless the output stalls, and keeps the track body byte count.
// ----------------------------------------------------------------------------
module mtes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  mtes_pkg::t_cmd     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mtes_pkg::t_out_item o_out_data
);
    import mtes_pkg::*;

    logic        r_ov;
    t_out_item   r_out;
    logic [4:0]  r_idx;
    logic [31:0] r_trk;

    logic        ld;
    logic [4:0]  last_idx;
    logic        is_last;
    logic        is_track;
    logic [7:0]  ev_byte;
    logic [7:0]  nxt_byte;
    logic [1:0]  grp;
    logic [1:0]  mk;
    logic [6:0]  grp_bits;

    assign ld      = !i_empty && (!r_ov || !i_out_stall);
    assign is_last = (r_idx == last_idx);
    assign o_pop   = ld && is_last;

    always_comb begin
        grp = i_head.vlq_last - r_idx[1:0];
        mk  = 2'(r_idx[2:0] - {1'b0, i_head.vlq_last} - 3'd1);
        unique case (grp)
            2'd0: grp_bits = i_head.delta[6:0];
            2'd1: grp_bits = i_head.delta[13:7];
            2'd2: grp_bits = i_head.delta[20:14];
            2'd3: grp_bits = i_head.delta[27:21];
        endcase
        if (r_idx <= 5'(i_head.vlq_last)) begin
            ev_byte = {grp != 2'd0, grp_bits};
        end else begin
            unique case (mk)
                2'd0:    ev_byte = i_head.message[7:0];
                2'd1:    ev_byte = i_head.message[15:8];
                default: ev_byte = i_head.message[23:16];
            endcase
        end
        unique case (i_head.action)
            ACT_START: begin
                last_idx = START_LAST;
                nxt_byte = start_byte(r_idx);
                is_track = (r_idx >= TRACK_FIRST);
            end
            ACT_END: begin
                last_idx = END_LAST;
                nxt_byte = end_byte(r_idx[1:0]);
                is_track = 1'b1;
            end
            default: begin
                last_idx = 5'(i_head.vlq_last) + 5'(i_head.msg_len);
                nxt_byte = ev_byte;
                is_track = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
            r_trk <= '0;
        end else begin
            if (ld) begin
                r_ov  <= 1'b1;
                r_idx <= is_last ? '0 : r_idx + 1'b1;
                if (i_head.action == ACT_START && r_idx == '0) begin
                    r_trk <= '0;
                end else if (is_track) begin
                    r_trk <= r_trk + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out.byte_out     <= nxt_byte;
            r_out.last         <= is_last;
            r_out.track_length <= (i_head.action == ACT_END && is_last) ? r_trk + 1'b1 : '0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

/* rtl/midi_track_event_serializer_top.sv */
// ----------------------------------------------------------------------------
// midi_track_event_serializer_top
// Format-0 Standard MIDI File byte stream writer.
// A transaction crosses the front-end stages, queue and output register.
// One byte per cycle unless stalled; start 29 bytes, event 1 to 7, end 4.
// The input side takes one transaction per cycle until the queue fills.
// Reset: synchronous, clears the pipeline, queue, tick and byte counters.
// ----------------------------------------------------------------------------
module midi_track_event_serializer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mtes_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mtes_pkg::t_out_item o_out_data
);
    import mtes_pkg::*;

    logic push;
    logic pop;
    logic empty;
    logic full;
    t_cmd cmd;
    t_cmd head;

    mtes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (cmd),
        .i_full     (full)
    );

    mtes_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    mtes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/mtes_checker.sv */
// ----------------------------------------------------------------------------
// mtes_checker
// Port-level checks on the serializer output stream.
// ----------------------------------------------------------------------------
module mtes_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input mtes_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mtes_pkg::t_out_item o_out_data
);
    import mtes_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    a_len_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.track_length != 32'd0 |-> o_out_data.last)
        else $error("track length outside final byte");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a transaction's byte burst");

endmodule

bind midi_track_event_serializer_top mtes_checker u_mtes_checker (.*);
